### rtl/cftc_pkg.sv
package cftc_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_MAX = 2'd1,
    ST_MIN = 2'd2
  } status_e;

  // Range limits on the year, then on the packed sub-year key
  localparam logic signed [15:0] YEAR_MAX = 16'sd29228;
  localparam logic signed [15:0] YEAR_MIN = -16'sd29228;

  localparam int unsigned KEY_W = 50;
  localparam logic [KEY_W-1:0] KEY_MAX =
    {4'd2, 5'd8, 5'd2, 6'd48, 6'd5, 10'd477, 10'd580, 4'd7};
  localparam logic [KEY_W-1:0] KEY_MIN =
    {4'd11, 5'd23, 5'd21, 6'd11, 6'd54, 10'd522, 10'd419, 4'd3};

  // Tick weights (100 ns units)
  localparam logic [40:0] TICKS_HOUR = 41'd36000000000;
  localparam logic [35:0] TICKS_MIN  = 36'd600000000;
  localparam logic [29:0] TICKS_SEC  = 30'd10000000;
  localparam logic [23:0] TICKS_MS   = 24'd10000;
  localparam logic [13:0] TICKS_US   = 14'd10;

  // One day is DAY_MULT << DAY_SHIFT ticks
  localparam logic signed [51:0] DAY_MULT  = 52'sd52734375;
  localparam int unsigned        DAY_SHIFT = 14;

  localparam logic [63:0] TICK_HALF = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SAT_HIGH  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SAT_LOW   = 64'd1;

  // Days before a month in a common year; month zero counts none,
  // months above twelve count the whole year
  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd0, 4'd1: d = 9'd0;
      4'd2:       d = 9'd31;
      4'd3:       d = 9'd59;
      4'd4:       d = 9'd90;
      4'd5:       d = 9'd120;
      4'd6:       d = 9'd151;
      4'd7:       d = 9'd181;
      4'd8:       d = 9'd212;
      4'd9:       d = 9'd243;
      4'd10:      d = 9'd273;
      4'd11:      d = 9'd304;
      4'd12:      d = 9'd334;
      default:    d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

### rtl/calendar_fields_to_tick_count_unit.sv
// Calendar date/time to 100 ns tick count.
//
// Input channel: in_valid_i / in_stall_o with the year..hundred_ns fields.
// A transfer happens on a rising edge where in_valid_i is high and
// in_stall_o is low. Output channel: out_valid_o / out_stall_i with
// instant_o (ticks offset by 2^63) and status_o (ok, saturated high,
// saturated low).
//
// Three register stages: range check, day count and time-field products;
// day-count multiply and time sum; final add. An input transfer passes
// through stages 1, 2 and 3 in order to out_valid_o, and one item is
// taken every cycle while in_stall_o is low. A stall on the output only
// holds the pipeline when every stage holds an item; bubbles are squeezed
// out first, so in_stall_o rises only when all three stages are full and
// out_stall_i is high. Reset empties the pipeline (all valid flags low);
// there is no other state.
module calendar_fields_to_tick_count_unit
  import cftc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic signed [15:0] year_i,
  input  logic [3:0]        month_i,
  input  logic [4:0]        day_i,
  input  logic [4:0]        hour_i,
  input  logic [5:0]        minute_i,
  input  logic [5:0]        second_i,
  input  logic [9:0]        millisecond_i,
  input  logic [9:0]        microsecond_i,
  input  logic [3:0]        hundred_ns_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [63:0]       instant_o,
  output logic [1:0]        status_o
);

  // Stage enables: a stage loads when empty or when the next one moves
  logic en1, en2, en3;
  logic s1_valid_q, s2_valid_q, s3_valid_q;

  assign en3 = !s3_valid_q || !out_stall_i;
  assign en2 = !s2_valid_q || en3;
  assign en1 = !s1_valid_q || en2;
  assign in_stall_o = !en1;

  // ---------------- stage 1: range check, day count, time products
  logic [KEY_W-1:0]  key;
  logic              above_max, below_min;
  status_e           status_s1_d;
  logic [15:0]       year_mag;
  logic              leap;
  logic [23:0]       year_days;
  logic [23:0]       whole_days;
  logic [8:0]        past_days;
  logic [4:0]        day_off;
  logic signed [25:0] days_s1_d;

  assign key = {month_i, day_i, hour_i, minute_i, second_i,
                millisecond_i, microsecond_i, hundred_ns_i};
  assign above_max = (year_i > YEAR_MAX) || ((year_i == YEAR_MAX) && (key > KEY_MAX));
  assign below_min = (year_i < YEAR_MIN) || ((year_i == YEAR_MIN) && (key < KEY_MIN));

  always_comb begin
    if (above_max) begin
      status_s1_d = ST_MAX;
    end else if (below_min) begin
      status_s1_d = ST_MIN;
    end else begin
      status_s1_d = ST_OK;
    end
  end

  // |year| * 365 + |year| / 4 days; positive years drop the current year
  assign year_mag   = year_i[15] ? 16'(-year_i) : 16'(year_i);
  assign leap       = (year_mag[1:0] == 2'b00);
  assign year_days  = 24'(year_mag) * 24'd365 + 24'(year_mag[15:2]);
  assign whole_days = (!year_i[15] && (year_i != 16'sd0)) ?
                      year_days - (leap ? 24'd366 : 24'd365) : year_days;
  assign past_days  = days_before(month_i) + 9'((leap && (month_i >= 4'd3)) ? 1 : 0);
  assign day_off    = (day_i != 5'd0) ? day_i - 5'd1 : 5'd0;

  always_comb begin
    if (year_i[15]) begin
      days_s1_d = -$signed({2'b00, whole_days});
    end else begin
      days_s1_d = $signed({2'b00, whole_days});
    end
    days_s1_d = days_s1_d + $signed({17'd0, past_days}) + $signed({21'd0, day_off});
  end

  status_e            s1_status_q;
  logic signed [25:0] s1_days_q;
  logic [40:0]        s1_hour_q;
  logic [35:0]        s1_min_q;
  logic [29:0]        s1_sec_q;
  logic [23:0]        s1_ms_q;
  logic [13:0]        s1_us_q;
  logic [3:0]         s1_hns_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_status_q <= status_s1_d;
      s1_days_q   <= days_s1_d;
      s1_hour_q   <= 41'(hour_i) * TICKS_HOUR;
      s1_min_q    <= 36'(minute_i) * TICKS_MIN;
      s1_sec_q    <= 30'(second_i) * TICKS_SEC;
      s1_ms_q     <= 24'(millisecond_i) * TICKS_MS;
      s1_us_q     <= 14'(microsecond_i) * TICKS_US;
      s1_hns_q    <= hundred_ns_i;
    end
  end

  // ---------------- stage 2: day multiply, sub-day sum
  logic signed [51:0] dprod_d;
  logic [40:0]        tsum_d;

  assign dprod_d = $signed({{26{s1_days_q[25]}}, s1_days_q}) * DAY_MULT;
  assign tsum_d  = s1_hour_q + 41'(s1_min_q) + 41'(s1_sec_q) + 41'(s1_ms_q)
                 + 41'(s1_us_q) + 41'(s1_hns_q);

  status_e            s2_status_q;
  logic signed [51:0] s2_dprod_q;
  logic [40:0]        s2_tsum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      s2_status_q <= s1_status_q;
      s2_dprod_q  <= dprod_d;
      s2_tsum_q   <= tsum_d;
    end
  end

  // ---------------- stage 3: offset add and saturation select
  logic [63:0] day_ticks;
  logic [63:0] instant_d;

  assign day_ticks = {{12{s2_dprod_q[51]}}, s2_dprod_q} << DAY_SHIFT;

  always_comb begin
    case (s2_status_q)
      ST_MAX:  instant_d = SAT_HIGH;
      ST_MIN:  instant_d = SAT_LOW;
      default: instant_d = TICK_HALF + day_ticks + 64'(s2_tsum_q);
    endcase
  end

  status_e     s3_status_q;
  logic [63:0] s3_instant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en3) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && s2_valid_q) begin
      s3_status_q  <= s2_status_q;
      s3_instant_q <= instant_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign instant_o   = s3_instant_q;
  assign status_o    = s3_status_q;

endmodule

### sim/tick_count_checker.sv
module tick_count_checker
  import cftc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [15:0] year_i,
  input  logic [3:0]         month_i,
  input  logic [4:0]         day_i,
  input  logic [4:0]         hour_i,
  input  logic [5:0]         minute_i,
  input  logic [5:0]         second_i,
  input  logic [9:0]         millisecond_i,
  input  logic [9:0]         microsecond_i,
  input  logic [3:0]         hundred_ns_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [63:0]        instant_i,
  input  logic [1:0]         status_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o
);

  typedef struct packed {
    logic [63:0] instant;
    status_e     status;
  } tick_result_t;

  // Tick weights, 100 ns units
  localparam logic [63:0] EPOCH_TICKS  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] T_US         = 64'd10;
  localparam logic [63:0] T_MS         = 64'd10000;
  localparam logic [63:0] T_SEC        = 64'd10000000;
  localparam logic [63:0] T_MIN        = 64'd600000000;
  localparam logic [63:0] T_HOUR       = 64'd36000000000;
  localparam logic [63:0] T_DAY        = 64'd864000000000;
  localparam logic [63:0] T_YEAR       = 64'd315360000000000;
  localparam logic [63:0] T_LEAP_YEAR  = 64'd316224000000000;
  localparam logic [63:0] T_FOUR_YEARS = 64'd1262304000000000;

  // Saturation bounds: year, then the sub-year fields packed most significant first
  localparam logic signed [15:0] TOP_YEAR    = 16'sd29228;
  localparam logic signed [15:0] BOTTOM_YEAR = -16'sd29228;
  localparam logic [49:0] TOP_KEY =
    {4'd2, 5'd8, 5'd2, 6'd48, 6'd5, 10'd477, 10'd580, 4'd7};
  localparam logic [49:0] BOTTOM_KEY =
    {4'd11, 5'd23, 5'd21, 6'd11, 6'd54, 10'd522, 10'd419, 4'd3};

  // Days elapsed before each month of a common year; entry 0 is month zero
  int unsigned days_prior [13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  tick_result_t expected_q [$];
  int unsigned  errors;

  function automatic tick_result_t convert_fields(
    input logic signed [15:0] yr,
    input logic [3:0]         mo,
    input logic [4:0]         dy,
    input logic [4:0]         hr,
    input logic [5:0]         mi,
    input logic [5:0]         sc,
    input logic [9:0]         ms,
    input logic [9:0]         us,
    input logic [3:0]         hn
  );
    tick_result_t res;
    logic [49:0]  key;
    int           year_mag;
    logic         leap;
    int unsigned  past_days;
    logic [63:0]  in_year;
    logic [63:0]  whole_years;
    key = {mo, dy, hr, mi, sc, ms, us, hn};
    if (yr > TOP_YEAR || (yr == TOP_YEAR && key > TOP_KEY)) begin
      res.instant = '1;
      res.status  = ST_MAX;
    end else if (yr < BOTTOM_YEAR || (yr == BOTTOM_YEAR && key < BOTTOM_KEY)) begin
      res.instant = 64'd1;
      res.status  = ST_MIN;
    end else begin
      year_mag = (yr < 0) ? -int'(yr) : int'(yr);
      leap     = (year_mag % 4) == 0;
      // months above twelve count the whole year as past
      past_days = (mo > 4'd12) ? 365 : days_prior[mo];
      if (leap && mo >= 4'd3) past_days++;
      in_year = 64'(past_days) * T_DAY;
      if (dy != 5'd0) in_year += (64'(dy) - 64'd1) * T_DAY;
      in_year += 64'(hr) * T_HOUR + 64'(mi) * T_MIN + 64'(sc) * T_SEC;
      in_year += 64'(ms) * T_MS + 64'(us) * T_US + 64'(hn);
      whole_years = 64'(year_mag / 4) * T_FOUR_YEARS + 64'(year_mag % 4) * T_YEAR;
      // positive years are zero-based
      if (yr > 0) whole_years -= leap ? T_LEAP_YEAR : T_YEAR;
      if (yr < 0) res.instant = EPOCH_TICKS - whole_years + in_year;
      else        res.instant = EPOCH_TICKS + whole_years + in_year;
      res.status = ST_OK;
    end
    return res;
  endfunction

  // Match output transfers against the oldest prediction, then queue new ones
  always @(posedge clk_i) begin
    tick_result_t exp_res;
    if (!rst_ni) begin
      errors = 0;
      expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: instant %h status %0d", instant_i, status_i);
        end else begin
          exp_res = expected_q.pop_front();
          if (instant_i !== exp_res.instant || status_i !== exp_res.status) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected instant %h status %0d, got instant %h status %0d",
                       exp_res.instant, exp_res.status, instant_i, status_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(convert_fields(year_i, month_i, day_i, hour_i, minute_i,
                                            second_i, millisecond_i, microsecond_i,
                                            hundred_ns_i));
    end
    errors_o  <= errors;
    pending_o <= expected_q.size();
  end

endmodule

### sim/calendar_fields_to_tick_count_unit_test.sv
module calendar_fields_to_tick_count_unit_test;

  localparam int MAX_WAIT     = 17;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_ITEMS = 1428;
  localparam int TAIL_CYCLES  = 8;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] year_i        = '0;
  logic [3:0]         month_i       = '0;
  logic [4:0]         day_i         = '0;
  logic [4:0]         hour_i        = '0;
  logic [5:0]         minute_i      = '0;
  logic [5:0]         second_i      = '0;
  logic [9:0]         millisecond_i = '0;
  logic [9:0]         microsecond_i = '0;
  logic [3:0]         hundred_ns_i  = '0;
  logic               out_valid_o;
  logic               out_stall_i   = 1'b0;
  logic [63:0]        instant_o;
  logic [1:0]         status_o;

  int unsigned mismatch_count;
  int unsigned pending_count;

  bit tx_burst     = 1'b0;
  bit rx_burst     = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_done    = 1'b0;

  // Saturation bounds field by field, and raw field widths
  int upper_key  [9]  = '{29228, 2, 8, 2, 48, 5, 477, 580, 7};
  int lower_key  [9]  = '{-29228, 11, 23, 21, 11, 54, 522, 419, 3};
  int field_w    [9]  = '{16, 4, 5, 5, 6, 6, 10, 10, 4};
  int month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  calendar_fields_to_tick_count_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .year_i        (year_i),
    .month_i       (month_i),
    .day_i         (day_i),
    .hour_i        (hour_i),
    .minute_i      (minute_i),
    .second_i      (second_i),
    .millisecond_i (millisecond_i),
    .microsecond_i (microsecond_i),
    .hundred_ns_i  (hundred_ns_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .instant_o     (instant_o),
    .status_o      (status_o)
  );

  tick_count_checker result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .year_i        (year_i),
    .month_i       (month_i),
    .day_i         (day_i),
    .hour_i        (hour_i),
    .minute_i      (minute_i),
    .second_i      (second_i),
    .millisecond_i (millisecond_i),
    .microsecond_i (microsecond_i),
    .hundred_ns_i  (hundred_ns_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .instant_i     (instant_o),
    .status_i      (status_o),
    .errors_o      (mismatch_count),
    .pending_o     (pending_count)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int pick_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input int yr, input int mo, input int dy, input int hr,
                           input int mi, input int sc, input int ms, input int us,
                           input int hn);
    int   gap;
    logic stalled;
    gap = pick_wait(tx_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    year_i        <= 16'(yr);
    month_i       <= 4'(mo);
    day_i         <= 5'(dy);
    hour_i        <= 5'(hr);
    minute_i      <= 6'(mi);
    second_i      <= 6'(sc);
    millisecond_i <= 10'(ms);
    microsecond_i <= 10'(us);
    hundred_ns_i  <= 4'(hn);
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  // Stop offering and wait until every predicted result has been seen
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  // Receiver: random stall before each transfer, one long hold-off on request
  initial begin : receiver
    int   n;
    int   served;
    logic got;
    served = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (served % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (hold_off_req && !hold_done) begin
        n = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        n = pick_wait(rx_burst);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        got = out_valid_o;
        @(posedge clk_i);
      end while (!got);
      served++;
    end
  end

  // Watchdog: ends the run after too many cycles without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus and verdict
  initial begin : stimulus
    int f [9];
    int i, j, k, r, sel, mlen, lim;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: range bounds, raw extremes and odd calendar cases
    send_item(1, 1, 1, 0, 0, 0, 0, 0, 0);
    send_item(-1, 1, 1, 0, 0, 0, 0, 0, 0);
    send_item(29228, 2, 8, 2, 48, 5, 477, 580, 7);
    send_item(29228, 2, 8, 2, 48, 5, 477, 580, 8);
    send_item(-29228, 11, 23, 21, 11, 54, 522, 419, 3);
    send_item(-29228, 11, 23, 21, 11, 54, 522, 419, 2);
    send_item(32767, 15, 31, 31, 63, 63, 1023, 1023, 15);
    send_item(-32768, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(29229, 1, 1, 0, 0, 0, 0, 0, 0);
    send_item(-29229, 12, 31, 23, 59, 59, 999, 999, 9);
    send_item(0, 3, 1, 0, 0, 0, 0, 0, 0);
    send_item(0, 1, 1, 0, 0, 0, 0, 0, 0);
    send_item(2024, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(2024, 13, 1, 0, 0, 0, 0, 0, 0);
    send_item(2023, 15, 1, 0, 0, 0, 0, 0, 0);
    send_item(2023, 2, 31, 23, 59, 59, 999, 999, 9);
    send_item(2024, 12, 31, 31, 63, 63, 1023, 1023, 15);
    send_item(-4, 3, 1, 12, 30, 30, 500, 500, 5);
    send_item(-5, 3, 1, 12, 30, 30, 500, 500, 5);
    send_item(4, 3, 1, 12, 30, 30, 500, 500, 5);
    send_item(29227, 15, 31, 31, 63, 63, 1023, 1023, 15);
    send_item(1, 12, 31, 23, 59, 59, 999, 999, 9);
    wait_drained();

    // Random: mostly well-formed dates, some near the bounds, some raw noise
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if (i == 600) hold_off_req = 1'b1;
      if (i == 900) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 70) begin
        sel = $urandom_range(0, 19);
        if (sel == 0)      f[0] = 0;
        else if (sel < 9)  f[0] = $urandom_range(1, 3000);
        else if (sel < 15) f[0] = $urandom_range(29218, 29228);
        else               f[0] = $urandom_range(1, 29228);
        if ($urandom_range(0, 1)) f[0] = -f[0];
        f[1] = $urandom_range(1, 12);
        mlen = month_days[f[1] - 1];
        if (f[1] == 2 && f[0] % 4 == 0) mlen = 29;
        f[2] = $urandom_range(1, mlen);
        f[3] = $urandom_range(0, 23);
        f[4] = $urandom_range(0, 59);
        f[5] = $urandom_range(0, 59);
        f[6] = $urandom_range(0, 999);
        f[7] = $urandom_range(0, 999);
        f[8] = $urandom_range(0, 9);
      end else if (r < 85) begin
        // match a bound up to field k, nudge field k, randomize the rest
        lim = $urandom_range(0, 1);
        k = $urandom_range(0, 8);
        for (j = 0; j < 9; j++) begin
          if (j < k)       f[j] = lim ? upper_key[j] : lower_key[j];
          else if (j == k) f[j] = (lim ? upper_key[j] : lower_key[j])
                                  + $urandom_range(0, 2) - 1;
          else             f[j] = $urandom_range(0, (1 << field_w[j]) - 1);
        end
      end else begin
        f[0] = int'($signed(16'($urandom_range(0, 65535))));
        for (j = 1; j < 9; j++) f[j] = $urandom_range(0, (1 << field_w[j]) - 1);
      end
      send_item(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8]);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
